>>> hdl/hcd_pkg.sv
// hcd_pkg: types, state and status codes and the hex digit decoder
// shared by the chunked transfer decoder. No dependencies.
`default_nettype none

package hcd_pkg;

    localparam int SIZE_BITS_DEFAULT = 32;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } hcd_in_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_NO_LEN    = 3'd1,
        STAT_NO_NL     = 3'd2,
        STAT_OVERFLOW  = 3'd3,
        STAT_PREMATURE = 3'd4,
        STAT_CLOSED    = 3'd5
    } hcd_status_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_valid;
        logic        end_of_body;
        hcd_status_t status;
    } hcd_out_t;

    typedef enum logic [8:0] {
        ST_FIRST_DIGIT = 9'b0_0000_0001,
        ST_SIZE        = 9'b0_0000_0010,
        ST_AFTER_SIZE  = 9'b0_0000_0100,
        ST_DATA        = 9'b0_0000_1000,
        ST_AFTER_DATA  = 9'b0_0001_0000,
        ST_TRAILER     = 9'b0_0010_0000,
        ST_TRAILER_TXT = 9'b0_0100_0000,
        ST_BODY_DONE   = 9'b0_1000_0000,
        ST_CLOSED      = 9'b1_0000_0000
    } hcd_state_t;

    localparam logic [7:0] CHAR_LF = 8'h0a;
    localparam logic [7:0] CHAR_CR = 8'h0d;

    // {is_hex, value}
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        r = 5'b0_0000;
        if (b >= "0" && b <= "9")
            r = {1'b1, 4'(b - "0")};
        else if (b >= "a" && b <= "f")
            r = {1'b1, 4'(b - "a" + 8'h0a)};
        else if (b >= "A" && b <= "F")
            r = {1'b1, 4'(b - "A" + 8'h0a)};
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/http_chunked_decoder.sv
// http_chunked_decoder: HTTP/1.1 chunked framing parser, one byte per request.
// Depends on hcd_pkg.
//
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  src      | src_valid, src_stall, src_req    | in
//  dst      | dst_valid, dst_stall, dst_req    | out
//  cfg      | cfg_wr_en, cfg_wr_data           | in
//
// One request per cycle while src_stall is low. Parser state updates in the
// acceptance cycle; each result is registered in a result register plus a
// skid register that hold results while dst stalls. src_stall rises only when
// the skid register is full. Reset clears parser state, mode and valids.
`default_nettype none

module http_chunked_decoder #(
    parameter int SIZE_BITS = hcd_pkg::SIZE_BITS_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             src_valid,
    output logic                  src_stall,
    input  wire hcd_pkg::hcd_in_t src_req,
    output logic                  dst_valid,
    input  wire logic             dst_stall,
    output hcd_pkg::hcd_out_t     dst_req,
    input  wire logic             cfg_wr_en,
    input  wire logic             cfg_wr_data
);
    import hcd_pkg::*;

    hcd_state_t           state_reg, state_next;
    logic [SIZE_BITS-1:0] chunk_reg, chunk_next;
    logic                 verbatim_reg;
    hcd_out_t             res;
    hcd_out_t             main_reg, skid_reg;
    logic                 main_valid_reg, skid_valid_reg;
    logic                 accept;
    logic [4:0]           hex;
    logic [SIZE_BITS-1:0] size_base;
    logic                 valid_c;
    logic                 eob_c;
    hcd_status_t          status_c;

    assign src_stall = skid_valid_reg;
    assign accept    = src_valid && !src_stall;
    assign hex       = hex_value(src_req.in_byte);
    assign size_base = (state_reg == ST_FIRST_DIGIT) ? '0 : chunk_reg;

    always_comb
    begin
        state_next = state_reg;
        chunk_next = chunk_reg;
        valid_c    = 1'b0;
        eob_c      = 1'b0;
        status_c   = STAT_OK;
        if (state_reg == ST_BODY_DONE || state_reg == ST_CLOSED)
        begin
            status_c = STAT_CLOSED;
        end
        else if (src_req.end_of_input)
        begin
            status_c   = STAT_PREMATURE;
            state_next = ST_CLOSED;
        end
        else
        begin
            unique case (state_reg)
                ST_FIRST_DIGIT, ST_SIZE:
                begin
                    if (!hex[4])
                    begin
                        if (state_reg == ST_SIZE)
                        begin
                            state_next = ST_AFTER_SIZE;
                            valid_c    = verbatim_reg;
                        end
                        else
                        begin
                            status_c   = STAT_NO_LEN;
                            state_next = ST_CLOSED;
                        end
                    end
                    else if (size_base[SIZE_BITS-1 -: 4] != 4'd0)
                    begin
                        status_c   = STAT_OVERFLOW;
                        state_next = ST_CLOSED;
                    end
                    else
                    begin
                        state_next = ST_SIZE;
                        chunk_next = {size_base[SIZE_BITS-5:0], hex[3:0]};
                        valid_c    = verbatim_reg;
                    end
                end
                ST_AFTER_SIZE:
                begin
                    if (src_req.in_byte == CHAR_LF)
                        state_next = (chunk_reg == '0) ? ST_TRAILER : ST_DATA;
                    valid_c = verbatim_reg;
                end
                ST_DATA:
                begin
                    if (chunk_reg != '0)
                        chunk_next = chunk_reg - SIZE_BITS'(1);
                    if (chunk_reg <= SIZE_BITS'(1))
                        state_next = ST_AFTER_DATA;
                    valid_c = 1'b1;
                end
                ST_AFTER_DATA:
                begin
                    if (src_req.in_byte == CHAR_LF)
                    begin
                        state_next = ST_FIRST_DIGIT;
                        valid_c    = verbatim_reg;
                    end
                    else if (src_req.in_byte == CHAR_CR)
                    begin
                        valid_c = verbatim_reg;
                    end
                    else
                    begin
                        status_c   = STAT_NO_NL;
                        state_next = ST_CLOSED;
                    end
                end
                ST_TRAILER:
                begin
                    if (src_req.in_byte == CHAR_LF)
                    begin
                        state_next = ST_BODY_DONE;
                        eob_c      = 1'b1;
                    end
                    else if (src_req.in_byte != CHAR_CR)
                    begin
                        state_next = ST_TRAILER_TXT;
                    end
                    valid_c = verbatim_reg;
                end
                ST_TRAILER_TXT:
                begin
                    if (src_req.in_byte == CHAR_LF)
                        state_next = ST_TRAILER;
                    valid_c = verbatim_reg;
                end
                default:
                begin
                    state_next = ST_CLOSED;
                end
            endcase
        end
        res.out_byte    = valid_c ? src_req.in_byte : 8'd0;
        res.out_valid   = valid_c;
        res.end_of_body = eob_c;
        res.status      = status_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_FIRST_DIGIT;
            chunk_reg    <= '0;
            verbatim_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                verbatim_reg <= cfg_wr_data;
            if (accept)
            begin
                state_reg <= state_next;
                chunk_reg <= chunk_next;
            end
        end
    end

    // result register with skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || !dst_stall)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || !dst_stall)
        begin
            if (skid_valid_reg)
                main_reg <= skid_reg;
            else if (accept)
                main_reg <= res;
        end
        else if (accept)
        begin
            skid_reg <= res;
        end
    end

    assign dst_valid = main_valid_reg;
    assign dst_req   = main_reg;

    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid register full while result register empty");

    a_closed_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BODY_DONE || state_reg == ST_CLOSED)
        |=> (state_reg == ST_BODY_DONE || state_reg == ST_CLOSED))
        else $error("parser left closed state without reset");

    a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DATA) |-> (chunk_reg != '0))
        else $error("data state with no bytes left");

    a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && dst_req.out_valid) |-> (dst_req.status == STAT_OK))
        else $error("byte passed with error status");

endmodule

`default_nettype wire
